FILE: hw/rtl/ftc_pkg.sv
// Shared types and constants for the fingertip classifier.
`timescale 1ns / 1ps
`default_nettype none

package ftc_pkg;

  // Reject reason codes, in test priority order
  typedef enum logic [2:0] {
    RSN_OK        = 3'd0,
    RSN_ANGLE     = 3'd1,
    RSN_TIP_BELOW = 3'd2,
    RSN_DEF_BELOW = 3'd3,
    RSN_TIP_NEAR  = 3'd4,
    RSN_DEF_NEAR  = 3'd5
  } reason_t;

  // Register indexes (selected by paddr[2])
  localparam logic REG_COS_MAX = 1'b0;
  localparam logic REG_COS_MIN = 1'b1;

  localparam int THR_BITS = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // Q1.15 reset values: cos 60 deg and cos 5 deg
  localparam logic [THR_BITS-1:0] COS_MAX_RESET = 16'd16384;
  localparam logic [THR_BITS-1:0] COS_MIN_RESET = 16'd32643;

  // Q12.4 minimum distance, squared: tip scaled by 16^2, defects by 64^2
  localparam int MIN_DIST_BITS = 16;
  localparam int TIP_NEAR_SHIFT = 8;
  localparam int DEF_NEAR_SHIFT = 12;

  // Q1.15 squared threshold against dot^2: lhs scaled by 2^30
  localparam int COS_SQ_SHIFT = 30;

endpackage

`default_nettype wire

FILE: hw/rtl/finger_tip_classifier.sv
// Top level: pipelined fingertip classifier with APB threshold registers.
// Path: a request taken at an edge (start high, busy low) moves through the stage 1 to 5
//   registers and then the output register onto out_strobe / out_is_finger / out_reject_reason.
// Throughput: one request per clock; busy is never raised, and the six-stage
//   multiplier pipeline has no loop, so a new request can enter every cycle.
// Reset: synchronous active-low rst_n empties the pipeline (valid bits and strobe
//   cleared) and loads the cosine thresholds with cos 60 deg and cos 5 deg.
`timescale 1ns / 1ps
`default_nettype none

module finger_tip_classifier #(
  parameter int COORD_BITS = 12
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  // Request channel
  input  wire                                        start,
  output logic                                       busy,
  input  wire  [COORD_BITS-1:0]                      in_far_a_x,
  input  wire  [COORD_BITS-1:0]                      in_far_a_y,
  input  wire  [COORD_BITS-1:0]                      in_tip_x,
  input  wire  [COORD_BITS-1:0]                      in_tip_y,
  input  wire  [COORD_BITS-1:0]                      in_far_c_x,
  input  wire  [COORD_BITS-1:0]                      in_far_c_y,
  input  wire  [COORD_BITS-1:0]                      in_palm_x,
  input  wire  [COORD_BITS-1:0]                      in_palm_y,
  input  wire  [ftc_pkg::MIN_DIST_BITS-1:0]          in_min_palm_distance,
  // Result channel
  output logic                                       out_strobe,
  output logic                                       out_is_finger,
  output logic [2:0]                                 out_reject_reason,
  // Configuration port
  input  wire                                        psel,
  input  wire                                        penable,
  input  wire                                        pwrite,
  input  wire  [ftc_pkg::APB_ADDR_BITS-1:0]          paddr,
  input  wire  [ftc_pkg::APB_DATA_BITS-1:0]          pwdata,
  output logic [ftc_pkg::APB_DATA_BITS-1:0]          prdata,
  output logic                                       pready
);

  // Difference of two coordinates: signed, one bit wider
  localparam int DW = COORD_BITS + 1;
  // Signed product of two differences
  localparam int PW = 2 * DW;
  // Square of a difference, always below 2^(2*COORD_BITS)
  localparam int SW = 2 * COORD_BITS;
  // Sum of two squares, and magnitude of a non-negative dot product
  localparam int NW = 2 * COORD_BITS + 1;
  // Squared-threshold width
  localparam int TW = 2 * ftc_pkg::THR_BITS;
  // Partial product of squared threshold with one half of n1*n2
  localparam int QW = TW + NW;
  // Full angle compare width
  localparam int WW = TW + 2 * NW;
  // Distance compare width
  localparam int CW = NW + TW;
  localparam int M2W = 2 * ftc_pkg::MIN_DIST_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ftc_pkg::THR_BITS-1:0] cos_max_r;
  logic [ftc_pkg::THR_BITS-1:0] cos_min_r;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_max_r <= ftc_pkg::COS_MAX_RESET;
      cos_min_r <= ftc_pkg::COS_MIN_RESET;
    end else if (cfg_wr) begin
      // Low address bits are ignored; paddr[2] picks the register
      if (paddr[2] == ftc_pkg::REG_COS_MAX) begin
        cos_max_r <= pwdata[ftc_pkg::THR_BITS-1:0];
      end else begin
        cos_min_r <= pwdata[ftc_pkg::THR_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ftc_pkg::REG_COS_MAX) begin
      prdata = {{(ftc_pkg::APB_DATA_BITS-ftc_pkg::THR_BITS){1'b0}}, cos_max_r};
    end else begin
      prdata = {{(ftc_pkg::APB_DATA_BITS-ftc_pkg::THR_BITS){1'b0}}, cos_min_r};
    end
  end

  // No back-pressure anywhere: take a request every cycle
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: coordinate differences and the two y-order tests
  // ---------------------------------------------------------------------------
  logic                 v1_nxt;
  logic                 v1_r;
  logic signed [DW-1:0] abx_r, aby_r, cbx_r, cby_r;   // A-B, C-B
  logic signed [DW-1:0] bpx_r, bpy_r;                 // B-P
  logic signed [DW-1:0] apx_r, apy_r, cpx_r, cpy_r;   // A-P, C-P
  logic [ftc_pkg::MIN_DIST_BITS-1:0] m1_r;
  logic                 tip_below1_r;
  logic                 def_below1_r;

  assign v1_nxt = start && !busy;

  function automatic logic signed [DW-1:0] sub_c(input logic [COORD_BITS-1:0] p,
                                                 input logic [COORD_BITS-1:0] q);
    sub_c = $signed({1'b0, p}) - $signed({1'b0, q});
  endfunction

  always_ff @(posedge clk) begin
    abx_r        <= sub_c(in_far_a_x, in_tip_x);
    aby_r        <= sub_c(in_far_a_y, in_tip_y);
    cbx_r        <= sub_c(in_far_c_x, in_tip_x);
    cby_r        <= sub_c(in_far_c_y, in_tip_y);
    bpx_r        <= sub_c(in_tip_x, in_palm_x);
    bpy_r        <= sub_c(in_tip_y, in_palm_y);
    apx_r        <= sub_c(in_far_a_x, in_palm_x);
    apy_r        <= sub_c(in_far_a_y, in_palm_y);
    cpx_r        <= sub_c(in_far_c_x, in_palm_x);
    cpy_r        <= sub_c(in_far_c_y, in_palm_y);
    m1_r         <= in_min_palm_distance;
    // Tip lower in the image than both defect points (y grows downward)
    tip_below1_r <= (in_tip_y > in_far_a_y) && (in_tip_y > in_far_c_y);
    // Both defect points lower than the palm centre
    def_below1_r <= (in_palm_y < in_far_a_y) && (in_palm_y < in_far_c_y);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: all small products in parallel
  // ---------------------------------------------------------------------------
  logic                 v2_r;
  logic signed [PW-1:0] dotx2_r, doty2_r;
  logic signed [PW-1:0] sqabx2_r, sqaby2_r, sqcbx2_r, sqcby2_r;
  logic signed [PW-1:0] sqbpx2_r, sqbpy2_r, sqapx2_r, sqapy2_r, sqcpx2_r, sqcpy2_r;
  logic [M2W-1:0]       m2_2_r;
  logic                 tip_below2_r;
  logic                 def_below2_r;

  always_ff @(posedge clk) begin
    dotx2_r      <= abx_r * cbx_r;
    doty2_r      <= aby_r * cby_r;
    sqabx2_r     <= abx_r * abx_r;
    sqaby2_r     <= aby_r * aby_r;
    sqcbx2_r     <= cbx_r * cbx_r;
    sqcby2_r     <= cby_r * cby_r;
    sqbpx2_r     <= bpx_r * bpx_r;
    sqbpy2_r     <= bpy_r * bpy_r;
    sqapx2_r     <= apx_r * apx_r;
    sqapy2_r     <= apy_r * apy_r;
    sqcpx2_r     <= cpx_r * cpx_r;
    sqcpy2_r     <= cpy_r * cpy_r;
    m2_2_r       <= m1_r * m1_r;
    tip_below2_r <= tip_below1_r;
    def_below2_r <= def_below1_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot product and squared lengths
  // ---------------------------------------------------------------------------
  logic                 v3_r;
  logic signed [PW-1:0] dot3_r;
  logic [NW-1:0]        n1_3_r, n2_3_r, dbp3_r, dap3_r, dcp3_r;
  logic [M2W-1:0]       m2_3_r;
  logic                 tip_below3_r;
  logic                 def_below3_r;

  function automatic logic [NW-1:0] sum_sq(input logic signed [PW-1:0] p,
                                           input logic signed [PW-1:0] q);
    sum_sq = {1'b0, p[SW-1:0]} + {1'b0, q[SW-1:0]};
  endfunction

  always_ff @(posedge clk) begin
    // Each term stays below 2^(2*COORD_BITS) in magnitude: no overflow in PW bits
    dot3_r       <= dotx2_r + doty2_r;
    n1_3_r       <= sum_sq(sqabx2_r, sqaby2_r);
    n2_3_r       <= sum_sq(sqcbx2_r, sqcby2_r);
    dbp3_r       <= sum_sq(sqbpx2_r, sqbpy2_r);
    dap3_r       <= sum_sq(sqapx2_r, sqapy2_r);
    dcp3_r       <= sum_sq(sqcpx2_r, sqcpy2_r);
    m2_3_r       <= m2_2_r;
    tip_below3_r <= tip_below2_r;
    def_below3_r <= def_below2_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: dot^2, n1*n2, threshold squares, distance tests
  // ---------------------------------------------------------------------------
  logic                 v4_r;
  logic [2*NW-1:0]      dd4_r;
  logic [2*NW-1:0]      nn4_r;
  logic [TW-1:0]        tmax2_4_r, tmin2_4_r;
  logic                 dot_neg4_r;
  logic                 side_zero4_r;
  logic                 tip_below4_r, def_below4_r, tip_near4_r, def_near4_r;
  logic [NW-1:0]        dmag3;

  // Non-negative dot fits NW bits; a negative one is rejected outright
  assign dmag3 = dot3_r[NW-1:0];

  function automatic logic near_test(input logic [NW-1:0]  d2,
                                     input logic [M2W-1:0] m2,
                                     input int             sh);
    logic [CW-1:0] lhs;
    logic [CW-1:0] rhs;
    lhs = CW'(d2) << sh;
    rhs = CW'(m2);
    near_test = lhs < rhs;
  endfunction

  always_ff @(posedge clk) begin
    dd4_r        <= dmag3 * dmag3;
    nn4_r        <= n1_3_r * n2_3_r;
    tmax2_4_r    <= cos_max_r * cos_max_r;
    tmin2_4_r    <= cos_min_r * cos_min_r;
    dot_neg4_r   <= dot3_r[PW-1];
    // Coincident points: cosine undefined, angle test passes
    side_zero4_r <= (n1_3_r == '0) || (n2_3_r == '0);
    tip_below4_r <= tip_below3_r;
    def_below4_r <= def_below3_r;
    tip_near4_r  <= near_test(dbp3_r, m2_3_r, ftc_pkg::TIP_NEAR_SHIFT);
    def_near4_r  <= near_test(dap3_r, m2_3_r, ftc_pkg::DEF_NEAR_SHIFT) ||
                    near_test(dcp3_r, m2_3_r, ftc_pkg::DEF_NEAR_SHIFT);
  end

  // ---------------------------------------------------------------------------
  // Stage 5: t^2 * n1*n2, split over the two halves of n1*n2
  // ---------------------------------------------------------------------------
  logic                 v5_r;
  logic [QW-1:0]        pmax_lo5_r, pmax_hi5_r, pmin_lo5_r, pmin_hi5_r;
  logic [2*NW-1:0]      dd5_r;
  logic                 dot_neg5_r, side_zero5_r;
  logic                 tip_below5_r, def_below5_r, tip_near5_r, def_near5_r;

  always_ff @(posedge clk) begin
    pmax_lo5_r   <= tmax2_4_r * nn4_r[NW-1:0];
    pmax_hi5_r   <= tmax2_4_r * nn4_r[2*NW-1:NW];
    pmin_lo5_r   <= tmin2_4_r * nn4_r[NW-1:0];
    pmin_hi5_r   <= tmin2_4_r * nn4_r[2*NW-1:NW];
    dd5_r        <= dd4_r;
    dot_neg5_r   <= dot_neg4_r;
    side_zero5_r <= side_zero4_r;
    tip_below5_r <= tip_below4_r;
    def_below5_r <= def_below4_r;
    tip_near5_r  <= tip_near4_r;
    def_near5_r  <= def_near4_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: recombine, compare dot^2 * 2^30 against both bounds, pick reason
  // ---------------------------------------------------------------------------
  logic [WW-1:0]        lhs6;
  logic [WW-1:0]        rhs_max6;
  logic [WW-1:0]        rhs_min6;
  logic                 angle_rej6;
  ftc_pkg::reason_t     reason_nxt;
  logic                 out_strobe_r;
  logic                 out_is_finger_r;
  ftc_pkg::reason_t     out_reason_r;

  assign lhs6     = WW'(dd5_r) << ftc_pkg::COS_SQ_SHIFT;
  assign rhs_max6 = (WW'(pmax_hi5_r) << NW) + WW'(pmax_lo5_r);
  assign rhs_min6 = (WW'(pmin_hi5_r) << NW) + WW'(pmin_lo5_r);

  // Reject below the wide-angle bound (negative cosine always is) or above
  // the narrow-angle bound
  assign angle_rej6 = !side_zero5_r &&
                      (dot_neg5_r || (lhs6 < rhs_max6) || (lhs6 > rhs_min6));

  // First failing test wins
  always_comb begin
    if (angle_rej6) begin
      reason_nxt = ftc_pkg::RSN_ANGLE;
    end else if (tip_below5_r) begin
      reason_nxt = ftc_pkg::RSN_TIP_BELOW;
    end else if (def_below5_r) begin
      reason_nxt = ftc_pkg::RSN_DEF_BELOW;
    end else if (tip_near5_r) begin
      reason_nxt = ftc_pkg::RSN_TIP_NEAR;
    end else if (def_near5_r) begin
      reason_nxt = ftc_pkg::RSN_DEF_NEAR;
    end else begin
      reason_nxt = ftc_pkg::RSN_OK;
    end
  end

  always_ff @(posedge clk) begin
    out_is_finger_r <= (reason_nxt == ftc_pkg::RSN_OK);
    out_reason_r    <= reason_nxt;
  end

  // Valid bits advance with the data; reset drops everything in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= v1_nxt;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      v5_r         <= v4_r;
      out_strobe_r <= v5_r;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_is_finger     = out_is_finger_r;
  assign out_reject_reason = out_reason_r;

`ifndef SYNTHESIS
  // Every request yields a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_strobe)
    else $error("request did not produce a result after six cycles");

  // No result strobe without a matching earlier request
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 6))
    else $error("result strobe without a matching request");

  // Accept flag and reason code agree
  a_flag_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_is_finger == (out_reject_reason == 3'(ftc_pkg::RSN_OK))))
    else $error("is_finger disagrees with reject_reason");

  // Reason code never beyond the last test
  a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_reject_reason <= 3'(ftc_pkg::RSN_DEF_NEAR)))
    else $error("reject_reason out of range");
`endif

endmodule

`default_nettype wire

FILE: dv/finger_tip_checker.sv
// Verdict scoreboard for the fingertip classifier: predicts each request's verdict and compares.
`timescale 1ns / 1ps

module finger_tip_checker #(
  parameter int COORD_BITS = 12
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire                                busy,
  input  wire  [COORD_BITS-1:0]              in_far_a_x,
  input  wire  [COORD_BITS-1:0]              in_far_a_y,
  input  wire  [COORD_BITS-1:0]              in_tip_x,
  input  wire  [COORD_BITS-1:0]              in_tip_y,
  input  wire  [COORD_BITS-1:0]              in_far_c_x,
  input  wire  [COORD_BITS-1:0]              in_far_c_y,
  input  wire  [COORD_BITS-1:0]              in_palm_x,
  input  wire  [COORD_BITS-1:0]              in_palm_y,
  input  wire  [ftc_pkg::MIN_DIST_BITS-1:0]  in_min_palm_distance,
  input  wire                                out_strobe,
  input  wire                                out_is_finger,
  input  wire  [2:0]                         out_reject_reason,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [ftc_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire  [ftc_pkg::APB_DATA_BITS-1:0]  pwdata,
  input  wire  [ftc_pkg::APB_DATA_BITS-1:0]  prdata,
  input  wire                                pready,
  output int                                 mismatches,
  output int                                 checked,
  output int                                 pending,
  output logic [5:0]                         reasons_seen
);

  typedef struct packed {
    logic             is_finger;
    ftc_pkg::reason_t reason;
  } verdict_t;

  verdict_t                         awaiting[$];
  logic [ftc_pkg::THR_BITS-1:0]     thr_max;
  logic [ftc_pkg::THR_BITS-1:0]     thr_min;
  int                               miss_count;
  int                               check_count;
  logic [5:0]                       seen;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    miss_count++;
  endtask

  function automatic longint span_sq(longint x0, longint y0, longint x1, longint y1);
    return (x0 - x1) * (x0 - x1) + (y0 - y1) * (y0 - y1);
  endfunction

  // Sign of (cos - thr/32768), from dot^2 * 2^30 against thr^2 * |u|^2 * |v|^2
  function automatic int cos_order(longint dot, longint nu, longint nv,
                                   logic [ftc_pkg::THR_BITS-1:0] thr);
    logic [127:0] lhs;
    logic [127:0] rhs;
    if (dot < 0) return -1;
    lhs = 128'(dot) * 128'(dot);
    lhs = lhs << ftc_pkg::COS_SQ_SHIFT;
    rhs = 128'(thr) * 128'(thr) * 128'(nu) * 128'(nv);
    if (lhs < rhs) return -1;
    if (lhs > rhs) return 1;
    return 0;
  endfunction

  function automatic verdict_t classify(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy, longint px, longint py,
                                        longint m, logic [ftc_pkg::THR_BITS-1:0] tmax,
                                        logic [ftc_pkg::THR_BITS-1:0] tmin);
    longint           nu;
    longint           nv;
    longint           dot;
    longint           m2;
    ftc_pkg::reason_t why;
    verdict_t         v;
    why = ftc_pkg::RSN_OK;
    nu = span_sq(ax, ay, bx, by);
    nv = span_sq(cx, cy, bx, by);
    m2 = m * m;
    // a zero-length side leaves the cosine undefined, so the angle test passes
    if (nu != 0 && nv != 0) begin
      dot = (ax - bx) * (cx - bx) + (ay - by) * (cy - by);
      if (cos_order(dot, nu, nv, tmax) < 0 || cos_order(dot, nu, nv, tmin) > 0)
        why = ftc_pkg::RSN_ANGLE;
    end
    if (why == ftc_pkg::RSN_OK && by > ay && by > cy) why = ftc_pkg::RSN_TIP_BELOW;
    if (why == ftc_pkg::RSN_OK && py < ay && py < cy) why = ftc_pkg::RSN_DEF_BELOW;
    if (why == ftc_pkg::RSN_OK &&
        (span_sq(bx, by, px, py) << ftc_pkg::TIP_NEAR_SHIFT) < m2)
      why = ftc_pkg::RSN_TIP_NEAR;
    if (why == ftc_pkg::RSN_OK &&
        ((span_sq(ax, ay, px, py) << ftc_pkg::DEF_NEAR_SHIFT) < m2 ||
         (span_sq(cx, cy, px, py) << ftc_pkg::DEF_NEAR_SHIFT) < m2))
      why = ftc_pkg::RSN_DEF_NEAR;
    v.is_finger = (why == ftc_pkg::RSN_OK);
    v.reason = why;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t                     want;
    logic [ftc_pkg::THR_BITS-1:0] held;
    if (!rst_n) begin
      awaiting.delete();
      thr_max = ftc_pkg::COS_MAX_RESET;
      thr_min = ftc_pkg::COS_MIN_RESET;
      miss_count = 0;
      check_count = 0;
      seen = '0;
    end else begin
      // retire the oldest expectation on each strobe
      if ($isunknown(out_strobe)) begin
        report("result strobe is unknown");
      end else if (out_strobe) begin
        if (awaiting.size() == 0) begin
          report("result strobe with no request outstanding");
        end else begin
          want = awaiting.pop_front();
          check_count++;
          if (out_is_finger !== want.is_finger)
            report($sformatf("is_finger got %b want %b", out_is_finger, want.is_finger));
          if (out_reject_reason !== want.reason)
            report($sformatf("reject_reason got %0d want %0d (%s)",
                             out_reject_reason, want.reason, want.reason.name()));
        end
      end
      // predict each accepted request with the thresholds now in force
      if (start && !busy) begin
        want = classify(longint'(in_far_a_x), longint'(in_far_a_y),
                        longint'(in_tip_x), longint'(in_tip_y),
                        longint'(in_far_c_x), longint'(in_far_c_y),
                        longint'(in_palm_x), longint'(in_palm_y),
                        longint'(in_min_palm_distance), thr_max, thr_min);
        awaiting = {awaiting, want};
        seen[want.reason] = 1'b1;
      end
      // track register writes, check register reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == ftc_pkg::REG_COS_MAX) thr_max = pwdata[ftc_pkg::THR_BITS-1:0];
          else thr_min = pwdata[ftc_pkg::THR_BITS-1:0];
        end else begin
          held = (paddr[2] == ftc_pkg::REG_COS_MAX) ? thr_max : thr_min;
          if (prdata !== ftc_pkg::APB_DATA_BITS'(held))
            report($sformatf("register read at %0d got %0d want %0d", paddr, prdata, held));
        end
      end
    end
    mismatches <= miss_count;
    checked <= check_count;
    pending <= awaiting.size();
    reasons_seen <= seen;
  end

endmodule

FILE: dv/tb_finger_tip_classifier.sv
// Testbench top for the fingertip classifier: stimulus, thresholds, watchdog and verdict.
`timescale 1ns / 1ps

module tb_finger_tip_classifier;

  localparam int COORD_BITS   = 12;
  localparam int CMAX         = (1 << COORD_BITS) - 1;
  localparam int PHASE_ITEMS  = 185;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [COORD_BITS-1:0]             ax;
    logic [COORD_BITS-1:0]             ay;
    logic [COORD_BITS-1:0]             bx;
    logic [COORD_BITS-1:0]             by;
    logic [COORD_BITS-1:0]             cx;
    logic [COORD_BITS-1:0]             cy;
    logic [COORD_BITS-1:0]             px;
    logic [COORD_BITS-1:0]             py;
    logic [ftc_pkg::MIN_DIST_BITS-1:0] m;
  } candidate_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic [COORD_BITS-1:0]               in_far_a_x;
  logic [COORD_BITS-1:0]               in_far_a_y;
  logic [COORD_BITS-1:0]               in_tip_x;
  logic [COORD_BITS-1:0]               in_tip_y;
  logic [COORD_BITS-1:0]               in_far_c_x;
  logic [COORD_BITS-1:0]               in_far_c_y;
  logic [COORD_BITS-1:0]               in_palm_x;
  logic [COORD_BITS-1:0]               in_palm_y;
  logic [ftc_pkg::MIN_DIST_BITS-1:0]   in_min_palm_distance;
  logic                                out_strobe;
  logic                                out_is_finger;
  logic [2:0]                          out_reject_reason;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [ftc_pkg::APB_ADDR_BITS-1:0]   paddr;
  logic [ftc_pkg::APB_DATA_BITS-1:0]   pwdata;
  logic [ftc_pkg::APB_DATA_BITS-1:0]   prdata;
  logic                                pready;

  // scoreboard outputs
  int                                  mismatches;
  int                                  checked;
  int                                  pending;
  logic [5:0]                          reasons_seen;

  int                                  sent_count = 0;
  int                                  settings_count = 1;
  int                                  quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  finger_tip_classifier #(.COORD_BITS(COORD_BITS)) dut (.*);

  finger_tip_checker #(.COORD_BITS(COORD_BITS)) scoreboard (.*);

  // Watchdog: count cycles with no request, no result and no register access.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Uniform pick in [lo, hi]; lo may be negative.
  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Clamp a coordinate into the pixel range.
  function automatic logic [COORD_BITS-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > CMAX) return COORD_BITS'(CMAX);
    return COORD_BITS'(v);
  endfunction

  function automatic candidate_t mk(int ax, int ay, int bx, int by, int cx, int cy,
                                    int px, int py, int m);
    candidate_t c;
    c.ax = clip(ax); c.ay = clip(ay);
    c.bx = clip(bx); c.by = clip(by);
    c.cx = clip(cx); c.cy = clip(cy);
    c.px = clip(px); c.py = clip(py);
    c.m  = ftc_pkg::MIN_DIST_BITS'(m);
    return c;
  endfunction

  // Mostly finger-shaped triples, then straight-line, clustered and fully random ones.
  function automatic candidate_t random_candidate();
    candidate_t c;
    int kind, bx, by, span, dx, dy, ka, kc;
    kind = pick(0, 99);
    bx = pick(0, CMAX);
    by = pick(0, CMAX);
    if (kind < 55) begin
      // defects below and to either side of the tip, palm further down
      span = pick(1, 500);
      c = mk(bx - pick(0, span), by + pick(-span / 8, 2 * span), bx, by,
             bx + pick(0, span), by + pick(-span / 8, 2 * span),
             bx + pick(-span, span), by + pick(-span / 4, 3 * span), 0);
      c.m = (pick(0, 4) == 0) ? ftc_pkg::MIN_DIST_BITS'(pick(0, 65535))
                              : ftc_pkg::MIN_DIST_BITS'(pick(0, 48 * span));
    end else if (kind < 70) begin
      // all three on one line: cosine of exactly one or minus one, or a zero side
      dx = pick(-20, 20);
      dy = pick(-20, 20);
      ka = pick(0, 40);
      kc = pick(0, 40);
      if (pick(0, 3) == 0) kc = -kc;
      c = mk(bx + ka * dx, by + ka * dy, bx, by, bx + kc * dx, by + kc * dy,
             pick(0, CMAX), pick(0, CMAX), pick(0, 4095));
    end else if (kind < 85) begin
      // tight cluster: frequent coincident points and ties in every compare
      c = mk(bx + pick(0, 3), by + pick(0, 3), bx + pick(0, 3), by + pick(0, 3),
             bx + pick(0, 3), by + pick(0, 3), bx + pick(0, 3), by + pick(0, 3),
             pick(0, 255));
    end else begin
      c = mk(pick(0, CMAX), pick(0, CMAX), pick(0, CMAX), pick(0, CMAX),
             pick(0, CMAX), pick(0, CMAX), pick(0, CMAX), pick(0, CMAX),
             pick(0, 65535));
    end
    return c;
  endfunction

  // Present one request and hold it until the edge that takes it.
  task automatic send_candidate(input candidate_t c);
    in_far_a_x <= c.ax;
    in_far_a_y <= c.ay;
    in_tip_x <= c.bx;
    in_tip_y <= c.by;
    in_far_c_x <= c.cx;
    in_far_c_y <= c.cy;
    in_palm_x <= c.px;
    in_palm_y <= c.py;
    in_min_palm_distance <= c.m;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // Drop start for a random run of cycles; each cycle idles with the given odds.
  task automatic idle_gap(input int idle_pct);
    while (pick(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic run_random(input int count, input int idle_pct);
    repeat (count) begin
      idle_gap(idle_pct);
      send_candidate(random_candidate());
    end
  endtask

  // Drop start and wait until every outstanding verdict has come back.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Setup phase, access phase, then an idle phase on the bus.
  task automatic reg_access(input logic idx, input logic write,
                            input logic [ftc_pkg::THR_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    // random upper bits: the registers keep only the low 16
    pwdata <= {16'(pick(0, 65535)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Load both cosine thresholds, then read both back.
  task automatic program_thresholds(input logic [ftc_pkg::THR_BITS-1:0] tmax,
                                    input logic [ftc_pkg::THR_BITS-1:0] tmin);
    reg_access(ftc_pkg::REG_COS_MAX, 1'b1, tmax);
    reg_access(ftc_pkg::REG_COS_MIN, 1'b1, tmin);
    reg_access(ftc_pkg::REG_COS_MAX, 1'b0, '0);
    reg_access(ftc_pkg::REG_COS_MIN, 1'b0, '0);
    settings_count++;
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_far_a_x <= '0;
    in_far_a_y <= '0;
    in_tip_x <= '0;
    in_tip_y <= '0;
    in_far_c_x <= '0;
    in_far_c_y <= '0;
    in_palm_x <= '0;
    in_palm_y <= '0;
    in_min_palm_distance <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset thresholds (cos 60 and cos 5 degrees).
    // Everything at zero: both sides zero-length, zero minimum distance.
    send_candidate(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Everything at its maximum: tip sits on the palm.
    send_candidate(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 65535));
    // Tip coincides with one defect, then with the other.
    send_candidate(mk(150, 100, 150, 100, 200, 300, 150, 400, 1600));
    send_candidate(mk(100, 300, 150, 100, 150, 100, 150, 400, 1600));
    // A clean raised finger.
    send_candidate(mk(100, 300, 150, 100, 200, 300, 150, 400, 1600));
    // Angle too wide, too narrow, obtuse, and a right angle.
    send_candidate(mk(0, 300, 150, 100, 300, 300, 150, 400, 1600));
    send_candidate(mk(149, 300, 150, 100, 151, 300, 150, 400, 1600));
    send_candidate(mk(0, 100, 150, 150, 300, 100, 150, 400, 1600));
    send_candidate(mk(100, 200, 100, 100, 200, 100, 150, 400, 1600));
    // Tip below both defects.
    send_candidate(mk(100, 100, 150, 300, 200, 100, 150, 400, 1600));
    // Both defects below the palm.
    send_candidate(mk(100, 300, 150, 100, 200, 300, 150, 200, 1600));
    // Tip one step too near the palm, then exactly at the limit.
    send_candidate(mk(100, 300, 150, 100, 200, 300, 150, 400, 4801));
    send_candidate(mk(100, 300, 150, 100, 200, 300, 150, 400, 4800));
    // First defect near the palm, then the second.
    send_candidate(mk(100, 300, 150, 100, 200, 300, 100, 310, 1000));
    send_candidate(mk(100, 300, 150, 100, 200, 300, 200, 305, 1000));
    // Zero minimum distance with the palm level with the defects.
    send_candidate(mk(100, 300, 150, 100, 200, 300, 150, 300, 0));
    // Alternating bit patterns on every field, and their complement.
    send_candidate(mk(12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'h555,
                      12'h555, 12'hAAA, 16'hA5A5));
    send_candidate(mk(12'h555, 12'hAAA, 12'hAAA, 12'h555, 12'h555, 12'hAAA,
                      12'hAAA, 12'h555, 16'h5A5A));
    run_random(PHASE_ITEMS, 0);

    // Widest window: any non-negative cosine passes.
    settle();
    program_thresholds(16'd0, 16'd32768);
    run_random(PHASE_ITEMS, 58);

    // Both thresholds at exactly one: only a straight, same-direction pair or a zero-length side passes the angle test.
    settle();
    program_thresholds(16'd32768, 16'd32768);
    send_candidate(mk(150, 200, 150, 100, 150, 300, 150, 400, 16));
    send_candidate(mk(150, 200, 150, 100, 150, 0, 150, 400, 16));
    run_random(PHASE_ITEMS, 11);

    // Thresholds above one, compared as given.
    settle();
    program_thresholds(16'hFFFF, 16'hFFFF);
    run_random(PHASE_ITEMS, 0);

    // Both at zero: only a right angle or a zero-length side passes the angle test.
    settle();
    program_thresholds(16'd0, 16'd0);
    run_random(PHASE_ITEMS, 58);

    settle();
    program_thresholds(ftc_pkg::THR_BITS'(pick(0, 65535)),
                       ftc_pkg::THR_BITS'(pick(0, 65535)));
    run_random(PHASE_ITEMS, 11);

    // Back to the reset values, written explicitly.
    settle();
    program_thresholds(ftc_pkg::COS_MAX_RESET, ftc_pkg::COS_MIN_RESET);
    run_random(PHASE_ITEMS, 0);

    // Drain, then give any stray strobe time to show up.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d candidates sent under %0d threshold settings, %0d verdicts compared",
             sent_count, settings_count, checked);
    $display("reject codes predicted (bit n set for code n): %b", reasons_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
